// ===== sv/wat_pkg.sv =====
// types, constants and microprogram for the weekly alarm table
`timescale 1ns / 1ps

package wat_pkg;

    localparam int MAX_SLOTS_DEF    = 8;
    localparam int CNT_W            = 5;
    localparam int SLOT_W           = 4;
    localparam int REQ_W            = 4;
    localparam int HOUR_W           = 5;
    localparam int MIN_W            = 6;
    localparam int DAYS_W           = 7;
    localparam int WAIT_W           = 14;
    localparam int TOD_W            = 11;
    localparam int ADJ_W            = 13;
    localparam int DELTA_W          = 12;
    localparam int PC_W             = 6;
    localparam int DIV60_W          = 22;
    localparam int DIV60_SHIFT      = 16;
    localparam int DIV60_MUL        = 1093;
    localparam int MINUTES_PER_DAY  = 1440;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int HOUR_MAX         = 23;
    localparam int MINUTE_MAX       = 59;
    localparam int SEARCH_DAYS      = 8;
    localparam int WEEK_DAYS        = 7;
    localparam int DEFAULT_HOUR     = 7;
    localparam logic [DAYS_W-1:0] ALL_DAYS = 7'h7F;

    typedef enum logic [REQ_W-1:0] {
        REQ_NEXT,
        REQ_READ,
        REQ_ADD,
        REQ_REMOVE,
        REQ_WRITE,
        REQ_ENABLE,
        REQ_EDIT_BEGIN,
        REQ_EDIT_ADJUST,
        REQ_COMMIT,
        REQ_READ_DRAFT
    } req_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic              enabled;
        logic [DAYS_W-1:0] days;
    } alarm_entry_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_SCAN_INIT,
        OP_EVAL,
        OP_UPDATE,
        OP_PTR_BEST,
        OP_OUT_FOUND,
        OP_OUT_ENTRY,
        OP_OUT_DRAFT,
        OP_OUT_OK,
        OP_OUT_REJECT,
        OP_ADD,
        OP_PTR_INC,
        OP_SHIFT,
        OP_REMOVE_END,
        OP_WRITE,
        OP_ENABLE,
        OP_PTR_ZERO,
        OP_DRAFT_BEGIN,
        OP_ADJ_ADD,
        OP_ADJ_FIX,
        OP_SPLIT_H,
        OP_SPLIT_M,
        OP_COMMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_NONE,
        COND_DISPATCH,
        COND_BAD_IDX,
        COND_BAD_REMOVE,
        COND_FULL,
        COND_WDAY_BAD,
        COND_NOT_FOUND,
        COND_PTR_GE_COUNT,
        COND_PTR_NEXT_LT_COUNT
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic load;
        logic exec;
        op_t  op;
    } dp_ctrl_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             bad_idx;
        logic             bad_remove;
        logic             full;
        logic             wday_bad;
        logic             not_found;
        logic             ptr_ge_count;
        logic             ptr_next_lt_count;
        logic [CNT_W-1:0] count;
    } dp_status_t;

    // program entry points and jump targets
    localparam logic [PC_W-1:0] L_DISPATCH   = PC_W'(0);
    localparam logic [PC_W-1:0] L_NEXT       = PC_W'(1);
    localparam logic [PC_W-1:0] L_SCAN_EVAL  = PC_W'(2);
    localparam logic [PC_W-1:0] L_READ       = PC_W'(6);
    localparam logic [PC_W-1:0] L_ADD        = PC_W'(8);
    localparam logic [PC_W-1:0] L_REMOVE     = PC_W'(11);
    localparam logic [PC_W-1:0] L_RM_SHIFT   = PC_W'(14);
    localparam logic [PC_W-1:0] L_RM_END     = PC_W'(15);
    localparam logic [PC_W-1:0] L_WRITE      = PC_W'(17);
    localparam logic [PC_W-1:0] L_ENABLE     = PC_W'(20);
    localparam logic [PC_W-1:0] L_BEGIN      = PC_W'(23);
    localparam logic [PC_W-1:0] L_ADJUST     = PC_W'(26);
    localparam logic [PC_W-1:0] L_COMMIT     = PC_W'(32);
    localparam logic [PC_W-1:0] L_READ_DRAFT = PC_W'(35);
    localparam logic [PC_W-1:0] L_REJECT     = PC_W'(36);
    localparam int UCODE_DEPTH = 37;

    function automatic alarm_entry_t default_entry(input logic en);
        alarm_entry_t e;
        e.hour    = HOUR_W'(DEFAULT_HOUR);
        e.minute  = '0;
        e.enabled = en;
        e.days    = ALL_DAYS;
        return e;
    endfunction

    function automatic ucode_t uw(input op_t op, input cond_t cond,
                                  input logic [PC_W-1:0] target);
        ucode_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    localparam ucode_t UCODE_ROM [UCODE_DEPTH] = '{
        uw(OP_NOP,         COND_DISPATCH,          L_DISPATCH),   // dispatch
        uw(OP_SCAN_INIT,   COND_WDAY_BAD,          L_REJECT),     // next
        uw(OP_EVAL,        COND_NONE,              L_DISPATCH),
        uw(OP_UPDATE,      COND_PTR_NEXT_LT_COUNT, L_SCAN_EVAL),
        uw(OP_PTR_BEST,    COND_NOT_FOUND,         L_REJECT),
        uw(OP_OUT_FOUND,   COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_BAD_IDX,           L_REJECT),     // read
        uw(OP_OUT_ENTRY,   COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_FULL,              L_REJECT),     // add
        uw(OP_ADD,         COND_NONE,              L_DISPATCH),
        uw(OP_OUT_ENTRY,   COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_BAD_REMOVE,        L_REJECT),     // remove
        uw(OP_PTR_INC,     COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_PTR_GE_COUNT,      L_RM_END),
        uw(OP_SHIFT,       COND_PTR_NEXT_LT_COUNT, L_RM_SHIFT),
        uw(OP_REMOVE_END,  COND_NONE,              L_DISPATCH),
        uw(OP_OUT_OK,      COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_BAD_IDX,           L_REJECT),     // write
        uw(OP_WRITE,       COND_NONE,              L_DISPATCH),
        uw(OP_OUT_ENTRY,   COND_NONE,              L_DISPATCH),
        uw(OP_NOP,         COND_BAD_IDX,           L_REJECT),     // enable
        uw(OP_ENABLE,      COND_NONE,              L_DISPATCH),
        uw(OP_OUT_ENTRY,   COND_NONE,              L_DISPATCH),
        uw(OP_PTR_ZERO,    COND_NONE,              L_DISPATCH),   // edit begin
        uw(OP_DRAFT_BEGIN, COND_NONE,              L_DISPATCH),
        uw(OP_OUT_DRAFT,   COND_NONE,              L_DISPATCH),
        uw(OP_ADJ_ADD,     COND_NONE,              L_DISPATCH),   // edit adjust
        uw(OP_ADJ_FIX,     COND_NONE,              L_DISPATCH),
        uw(OP_ADJ_FIX,     COND_NONE,              L_DISPATCH),
        uw(OP_SPLIT_H,     COND_NONE,              L_DISPATCH),
        uw(OP_SPLIT_M,     COND_NONE,              L_DISPATCH),
        uw(OP_OUT_DRAFT,   COND_NONE,              L_DISPATCH),
        uw(OP_PTR_ZERO,    COND_NONE,              L_DISPATCH),   // commit
        uw(OP_COMMIT,      COND_NONE,              L_DISPATCH),
        uw(OP_OUT_ENTRY,   COND_NONE,              L_DISPATCH),
        uw(OP_OUT_DRAFT,   COND_NONE,              L_DISPATCH),   // read draft
        uw(OP_OUT_REJECT,  COND_NONE,              L_DISPATCH)    // reject
    };

    function automatic ucode_t ucode_fetch(input logic [PC_W-1:0] pc);
        ucode_t w;
        if (int'(pc) < UCODE_DEPTH) begin
            w = UCODE_ROM[pc];
        end else begin
            w = uw(OP_OUT_REJECT, COND_NONE, L_DISPATCH);
        end
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch_target(input logic [REQ_W-1:0] req);
        logic [PC_W-1:0] t;
        case (req)
            REQ_NEXT:        t = L_NEXT;
            REQ_READ:        t = L_READ;
            REQ_ADD:         t = L_ADD;
            REQ_REMOVE:      t = L_REMOVE;
            REQ_WRITE:       t = L_WRITE;
            REQ_ENABLE:      t = L_ENABLE;
            REQ_EDIT_BEGIN:  t = L_BEGIN;
            REQ_EDIT_ADJUST: t = L_ADJUST;
            REQ_COMMIT:      t = L_COMMIT;
            REQ_READ_DRAFT:  t = L_READ_DRAFT;
            default:         t = L_REJECT;
        endcase
        return t;
    endfunction

    function automatic logic is_out_op(input op_t op);
        return (op == OP_OUT_FOUND) || (op == OP_OUT_ENTRY) || (op == OP_OUT_DRAFT) ||
               (op == OP_OUT_OK) || (op == OP_OUT_REJECT);
    endfunction

endpackage

// ===== sv/weekly_alarm_table_next_alarm.sv =====
// top level of the weekly alarm table: request handshake, microcode sequencer, result channel
//
// one request in on the s_ channel (valid/ready), one result out on the m_ channel.
// s_req_type picks next-alarm search, read, add, remove, write, enable, or one of
// the draft requests (begin, adjust, commit, read draft); unknown codes are rejected
// a request is taken only while no request is in progress (s_ready = not busy)
// a small program in a read-only table runs each request one step per cycle, but a result step may stall:
// dispatch, then the steps for that request, then a result step
// next alarm takes two steps per slot (evaluate, then update) through the one slot read port,
// and remove runs a shift step for each slot moved down; one request at a time
// the result sits in an output register: a new request is taken while it waits,
// and only the final result step of that request holds off until m_ready frees it
// reset (aresetn low, synchronous) restores 7:00 all-days entries, only slot 0
// enabled, count 1, draft equal to slot 0, and an empty result channel
`timescale 1ns / 1ps

module weekly_alarm_table_next_alarm
    import wat_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [REQ_W-1:0]          s_req_type,
    input  logic [SLOT_W-1:0]         s_slot_index,
    input  logic [7:0]                s_entry_hour,
    input  logic [7:0]                s_entry_minute,
    input  logic [7:0]                s_entry_days,
    input  logic                      s_entry_enabled,
    input  logic [2:0]                s_now_wday,
    input  logic [HOUR_W-1:0]         s_now_hour,
    input  logic [MIN_W-1:0]          s_now_minute,
    input  logic signed [DELTA_W-1:0] s_delta_minutes,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic [SLOT_W-1:0]         m_slot_out,
    output logic [HOUR_W-1:0]         m_alarm_hour,
    output logic [MIN_W-1:0]          m_alarm_minute,
    output logic                      m_alarm_enabled,
    output logic [DAYS_W-1:0]         m_alarm_days,
    output logic [WAIT_W-1:0]         m_minutes_until,
    output logic [CNT_W-1:0]          m_alarm_count
);

    // sequencer state
    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            m_valid_reg, m_valid_next;

    ucode_t     uc;
    logic       out_op;
    logic       stall;
    logic       exec;
    logic       accept;
    logic       jump;
    dp_ctrl_t   ctrl;
    dp_status_t status;

    // fetch the control word for the current step
    assign uc     = ucode_fetch(pc_reg);
    assign out_op = is_out_op(uc.op);
    // result step waits while the previous result is still unclaimed
    assign stall  = out_op && m_valid_reg && !m_ready;
    assign exec   = busy_reg && !stall;
    assign accept = s_valid && !busy_reg;

    assign s_ready = !busy_reg;
    assign m_valid = m_valid_reg;

    assign ctrl.load = accept;
    assign ctrl.exec = exec;
    assign ctrl.op   = uc.op;

    // jump condition select
    always_comb begin
        case (uc.cond)
            COND_NONE:              jump = 1'b0;
            COND_DISPATCH:          jump = 1'b1;
            COND_BAD_IDX:           jump = status.bad_idx;
            COND_BAD_REMOVE:        jump = status.bad_remove;
            COND_FULL:              jump = status.full;
            COND_WDAY_BAD:          jump = status.wday_bad;
            COND_NOT_FOUND:         jump = status.not_found;
            COND_PTR_GE_COUNT:      jump = status.ptr_ge_count;
            COND_PTR_NEXT_LT_COUNT: jump = status.ptr_next_lt_count;
            default:                jump = 1'b0;
        endcase
    end

    // step counter and busy flag
    always_comb begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept) begin
            busy_next = 1'b1;
            pc_next   = L_DISPATCH;
        end else if (exec) begin
            if (out_op) begin
                // result step ends the request
                busy_next = 1'b0;
                pc_next   = L_DISPATCH;
            end else if (jump) begin
                pc_next = (uc.cond == COND_DISPATCH) ? dispatch_target(status.req) : uc.target;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    // result channel valid
    always_comb begin
        if (exec && out_op) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= L_DISPATCH;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    wat_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl            (ctrl),
        .s_req_type      (s_req_type),
        .s_slot_index    (s_slot_index),
        .s_entry_hour    (s_entry_hour),
        .s_entry_minute  (s_entry_minute),
        .s_entry_days    (s_entry_days),
        .s_entry_enabled (s_entry_enabled),
        .s_now_wday      (s_now_wday),
        .s_now_hour      (s_now_hour),
        .s_now_minute    (s_now_minute),
        .s_delta_minutes (s_delta_minutes),
        .status          (status),
        .m_ok            (m_ok),
        .m_slot_out      (m_slot_out),
        .m_alarm_hour    (m_alarm_hour),
        .m_alarm_minute  (m_alarm_minute),
        .m_alarm_enabled (m_alarm_enabled),
        .m_alarm_days    (m_alarm_days),
        .m_minutes_until (m_minutes_until),
        .m_alarm_count   (m_alarm_count)
    );

    // idle sequencer always parks on the dispatch step
    a_idle_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pc_reg == L_DISPATCH)
        else $error("sequencer idle away from dispatch step");

    // slots in use stay between one and the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.count != '0 && status.count <= CNT_W'(MAX_SLOTS))
        else $error("alarm count out of range");

    // a result step frees the sequencer and presents the result
    a_emit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && out_op) |=> (!busy_reg && m_valid_reg))
        else $error("result step did not complete the request");

    // an accepted request starts at dispatch
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (busy_reg && pc_reg == L_DISPATCH))
        else $error("accepted request did not start at dispatch");

endmodule

// ===== sv/wat_datapath.sv =====
// datapath of the alarm table: slot registers, count, draft, scan and result registers
`timescale 1ns / 1ps

module wat_datapath
    import wat_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dp_ctrl_t                  ctrl,
    input  logic [REQ_W-1:0]          s_req_type,
    input  logic [SLOT_W-1:0]         s_slot_index,
    input  logic [7:0]                s_entry_hour,
    input  logic [7:0]                s_entry_minute,
    input  logic [7:0]                s_entry_days,
    input  logic                      s_entry_enabled,
    input  logic [2:0]                s_now_wday,
    input  logic [HOUR_W-1:0]         s_now_hour,
    input  logic [MIN_W-1:0]          s_now_minute,
    input  logic signed [DELTA_W-1:0] s_delta_minutes,
    output dp_status_t                status,
    output logic                      m_ok,
    output logic [SLOT_W-1:0]         m_slot_out,
    output logic [HOUR_W-1:0]         m_alarm_hour,
    output logic [MIN_W-1:0]          m_alarm_minute,
    output logic                      m_alarm_enabled,
    output logic [DAYS_W-1:0]         m_alarm_days,
    output logic [WAIT_W-1:0]         m_minutes_until,
    output logic [CNT_W-1:0]          m_alarm_count
);

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(MAX_SLOTS);

    // latched request
    logic [REQ_W-1:0]          req_reg;
    logic [SLOT_W-1:0]         idx_reg;
    logic [7:0]                e_hour_reg;
    logic [7:0]                e_min_reg;
    logic [7:0]                e_days_reg;
    logic                      e_en_reg;
    logic [2:0]                wday_reg;
    logic [HOUR_W-1:0]         n_hour_reg;
    logic [MIN_W-1:0]          n_min_reg;
    logic signed [DELTA_W-1:0] delta_reg;

    alarm_entry_t     slot_tbl_reg [MAX_SLOTS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    alarm_entry_t     wr_data;
    alarm_entry_t     rd_entry;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    alarm_entry_t            draft_reg, draft_next;
    logic [TOD_W-1:0]        now_tod_reg, now_tod_next;
    logic                    cand_valid_reg, cand_valid_next;
    logic [WAIT_W-1:0]       cand_wait_reg, cand_wait_next;
    logic                    found_reg, found_next;
    logic [CNT_W-1:0]        best_slot_reg, best_slot_next;
    logic [WAIT_W-1:0]       best_wait_reg, best_wait_next;
    logic signed [ADJ_W-1:0] adj_reg, adj_next;

    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] slot_out_reg, slot_out_next;
    alarm_entry_t      res_entry_reg, res_entry_next;
    logic [WAIT_W-1:0] until_reg, until_next;
    logic [CNT_W-1:0]  res_count_reg, res_count_next;

    // scan evaluation signals
    logic [TOD_W-1:0]          ent_tod;
    logic signed [DELTA_W-1:0] ent_delta;
    logic [SEARCH_DAYS-1:0]    day_hit;
    logic [2:0]                first_day;
    logic [DAYS_W:0]           days_ext;
    logic [3:0]                day_sum;
    logic [2:0]                day_pos;
    logic signed [WAIT_W:0]    cand_sum;

    // draft arithmetic
    logic [TOD_W-1:0]   draft_tod;
    logic [DIV60_W-1:0] div_prod;
    logic [TOD_W-1:0]   hour_mins;

    logic [HOUR_W-1:0] now_hour_c;
    logic [MIN_W-1:0]  now_min_c;
    alarm_entry_t      write_entry;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            req_reg    <= s_req_type;
            idx_reg    <= s_slot_index;
            e_hour_reg <= s_entry_hour;
            e_min_reg  <= s_entry_minute;
            e_days_reg <= s_entry_days;
            e_en_reg   <= s_entry_enabled;
            wday_reg   <= s_now_wday;
            n_hour_reg <= s_now_hour;
            n_min_reg  <= s_now_minute;
            delta_reg  <= s_delta_minutes;
        end
    end

    assign rd_entry = (ptr_reg < SLOTS) ? slot_tbl_reg[ptr_reg[IDX_W-1:0]] : default_entry(1'b0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                slot_tbl_reg[i] <= default_entry(i == 0);
            end
        end else if (wr_en) begin
            slot_tbl_reg[wr_addr] <= wr_data;
        end
    end

    // find the first day in the window on which this slot fires
    always_comb begin
        ent_tod   = TOD_W'(rd_entry.hour) * TOD_W'(MINUTES_PER_HOUR) + TOD_W'(rd_entry.minute);
        ent_delta = $signed({1'b0, ent_tod}) - $signed({1'b0, now_tod_reg});
        days_ext  = {1'b0, rd_entry.days};
        day_hit   = '0;
        day_sum   = '0;
        day_pos   = '0;
        for (int d = 0; d < SEARCH_DAYS; d++) begin
            day_sum = 4'({1'b0, wday_reg}) + 4'(d);
            day_pos = (day_sum >= 4'(WEEK_DAYS)) ? 3'(day_sum - 4'(WEEK_DAYS)) : day_sum[2:0];
            day_hit[d] = rd_entry.enabled && days_ext[day_pos];
        end
        day_hit[0] = day_hit[0] && (ent_delta > 0);
        first_day = '0;
        for (int d = SEARCH_DAYS - 1; d >= 0; d--) begin
            if (day_hit[d]) begin
                first_day = 3'(d);
            end
        end
        cand_sum = $signed({1'b0, WAIT_W'(first_day) * WAIT_W'(MINUTES_PER_DAY)})
                 + (WAIT_W+1)'(ent_delta);
    end

    always_comb begin
        now_hour_c  = (n_hour_reg > HOUR_W'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : n_hour_reg;
        now_min_c   = (n_min_reg > MIN_W'(MINUTE_MAX)) ? MIN_W'(MINUTE_MAX) : n_min_reg;
        draft_tod   = TOD_W'(draft_reg.hour) * TOD_W'(MINUTES_PER_HOUR) + TOD_W'(draft_reg.minute);
        div_prod    = DIV60_W'(adj_reg[TOD_W-1:0]) * DIV60_W'(DIV60_MUL);
        hour_mins   = TOD_W'(draft_reg.hour) * TOD_W'(MINUTES_PER_HOUR);
        write_entry.hour    = (e_hour_reg > 8'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : e_hour_reg[HOUR_W-1:0];
        write_entry.minute  = (e_min_reg > 8'(MINUTE_MAX)) ? MIN_W'(MINUTE_MAX) : e_min_reg[MIN_W-1:0];
        write_entry.enabled = e_en_reg;
        write_entry.days    = e_days_reg[DAYS_W-1:0];
    end

    always_comb begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        draft_next      = draft_reg;
        now_tod_next    = now_tod_reg;
        cand_valid_next = cand_valid_reg;
        cand_wait_next  = cand_wait_reg;
        found_next      = found_reg;
        best_slot_next  = best_slot_reg;
        best_wait_next  = best_wait_reg;
        adj_next        = adj_reg;
        ok_next         = ok_reg;
        slot_out_next   = slot_out_reg;
        res_entry_next  = res_entry_reg;
        until_next      = until_reg;
        res_count_next  = res_count_reg;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IDX_W-1:0];
        wr_data         = rd_entry;

        if (ctrl.load) begin
            ptr_next = CNT_W'(s_slot_index);
        end

        if (ctrl.exec) begin
            case (ctrl.op)
                OP_SCAN_INIT: begin
                    ptr_next     = '0;
                    found_next   = 1'b0;
                    now_tod_next = TOD_W'(now_hour_c) * TOD_W'(MINUTES_PER_HOUR) + TOD_W'(now_min_c);
                end
                OP_EVAL: begin
                    cand_valid_next = |day_hit;
                    cand_wait_next  = cand_sum[WAIT_W-1:0];
                end
                OP_UPDATE: begin
                    // strict compare keeps the lowest slot on a tie
                    if (cand_valid_reg && (!found_reg || cand_wait_reg < best_wait_reg)) begin
                        found_next     = 1'b1;
                        best_slot_next = ptr_reg;
                        best_wait_next = cand_wait_reg;
                    end
                    ptr_next = ptr_reg + 1'b1;
                end
                OP_PTR_BEST: ptr_next = best_slot_reg;
                OP_PTR_INC:  ptr_next = ptr_reg + 1'b1;
                OP_PTR_ZERO: ptr_next = '0;
                OP_ADD: begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    wr_data    = default_entry(1'b0);
                    ptr_next   = count_reg;
                    count_next = count_reg + 1'b1;
                end
                OP_SHIFT: begin
                    wr_en    = 1'b1;
                    wr_addr  = IDX_W'(ptr_reg - 1'b1);
                    wr_data  = rd_entry;
                    ptr_next = ptr_reg + 1'b1;
                end
                OP_REMOVE_END: begin
                    wr_en      = 1'b1;
                    wr_addr    = IDX_W'(count_reg - 1'b1);
                    wr_data    = default_entry(1'b0);
                    count_next = count_reg - 1'b1;
                end
                OP_WRITE: begin
                    wr_en   = 1'b1;
                    wr_data = write_entry;
                end
                OP_ENABLE: begin
                    wr_en           = 1'b1;
                    wr_data         = rd_entry;
                    wr_data.enabled = e_en_reg;
                end
                OP_COMMIT: begin
                    wr_en          = 1'b1;
                    wr_data        = rd_entry;
                    wr_data.hour   = draft_reg.hour;
                    wr_data.minute = draft_reg.minute;
                end
                OP_DRAFT_BEGIN: draft_next = rd_entry;
                OP_ADJ_ADD: begin
                    adj_next = $signed({2'b00, draft_tod}) + ADJ_W'(delta_reg);
                end
                OP_ADJ_FIX: begin
                    if (adj_reg < 0) begin
                        adj_next = adj_reg + ADJ_W'(MINUTES_PER_DAY);
                    end else if (adj_reg >= ADJ_W'(MINUTES_PER_DAY)) begin
                        adj_next = adj_reg - ADJ_W'(MINUTES_PER_DAY);
                    end
                end
                OP_SPLIT_H: draft_next.hour = div_prod[DIV60_SHIFT +: HOUR_W];
                OP_SPLIT_M: draft_next.minute = MIN_W'(adj_reg[TOD_W-1:0] - hour_mins);
                OP_OUT_FOUND: begin
                    ok_next        = 1'b1;
                    slot_out_next  = best_slot_reg[SLOT_W-1:0];
                    res_entry_next = rd_entry;
                    until_next     = best_wait_reg;
                    res_count_next = count_reg;
                end
                OP_OUT_ENTRY: begin
                    ok_next        = 1'b1;
                    slot_out_next  = ptr_reg[SLOT_W-1:0];
                    res_entry_next = rd_entry;
                    until_next     = '0;
                    res_count_next = count_reg;
                end
                OP_OUT_DRAFT: begin
                    ok_next        = 1'b1;
                    slot_out_next  = '0;
                    res_entry_next = draft_reg;
                    until_next     = '0;
                    res_count_next = count_reg;
                end
                OP_OUT_OK: begin
                    ok_next        = 1'b1;
                    slot_out_next  = '0;
                    res_entry_next = '0;
                    until_next     = '0;
                    res_count_next = count_reg;
                end
                OP_OUT_REJECT: begin
                    ok_next        = 1'b0;
                    slot_out_next  = '0;
                    res_entry_next = '0;
                    until_next     = '0;
                    res_count_next = count_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(1);
            draft_reg <= default_entry(1'b1);
        end else begin
            count_reg <= count_next;
            draft_reg <= draft_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        now_tod_reg    <= now_tod_next;
        cand_valid_reg <= cand_valid_next;
        cand_wait_reg  <= cand_wait_next;
        found_reg      <= found_next;
        best_slot_reg  <= best_slot_next;
        best_wait_reg  <= best_wait_next;
        adj_reg        <= adj_next;
        ok_reg         <= ok_next;
        slot_out_reg   <= slot_out_next;
        res_entry_reg  <= res_entry_next;
        until_reg      <= until_next;
        res_count_reg  <= res_count_next;
    end

    always_comb begin
        status.req               = req_reg;
        status.bad_idx           = CNT_W'(idx_reg) >= count_reg;
        status.bad_remove        = (CNT_W'(idx_reg) >= count_reg) || (idx_reg == '0);
        status.full              = count_reg >= SLOTS;
        status.wday_bad          = wday_reg >= 3'(WEEK_DAYS);
        status.not_found         = !found_reg;
        status.ptr_ge_count      = ptr_reg >= count_reg;
        status.ptr_next_lt_count = (CNT_W'(ptr_reg + 1'b1)) < count_reg;
        status.count             = count_reg;
    end

    assign m_ok            = ok_reg;
    assign m_slot_out      = slot_out_reg;
    assign m_alarm_hour    = res_entry_reg.hour;
    assign m_alarm_minute  = res_entry_reg.minute;
    assign m_alarm_enabled = res_entry_reg.enabled;
    assign m_alarm_days    = res_entry_reg.days;
    assign m_minutes_until = until_reg;
    assign m_alarm_count   = res_count_reg;

endmodule
